// ===== sv/dtr_pkg.sv =====
`default_nettype none

package dtr_pkg;

    localparam logic [1:0] FUNC_NONE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [1:0] SEL_DIV   = 2'd0;
    localparam logic [1:0] SEL_COUNT = 2'd1;
    localparam logic [1:0] SEL_MOD   = 2'd2;
    localparam logic [1:0] SEL_CTRL  = 2'd3;

    localparam logic [1:0] RATE_256 = 2'd0;
    localparam logic [1:0] RATE_4   = 2'd1;
    localparam logic [1:0] RATE_16  = 2'd2;
    localparam logic [1:0] RATE_64  = 2'd3;

    localparam logic [4:0] CTRL_READ_ONES = 5'b11111;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } rsp_t;

    function automatic logic rate_level(input logic [15:0] cnt, input logic [1:0] rate);
        logic level;
        begin
            case (rate)
                RATE_256: level = cnt[7];
                RATE_4:   level = cnt[1];
                RATE_16:  level = cnt[3];
                default:  level = cnt[5];
            endcase
            return level;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/dtr_core.sv =====
`default_nettype none

module dtr_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire dtr_pkg::req_t req,
    output dtr_pkg::rsp_t      rsp
);
    import dtr_pkg::*;

    logic [15:0] cycle_counter_reg, cycle_counter_next;
    logic [7:0]  tick_count_reg, tick_count_next;
    logic [7:0]  reload_value_reg, reload_value_next;
    logic [2:0]  control_reg, control_next;
    logic        prev_clk_reg, prev_clk_next;
    logic        prev_top_reg, prev_top_next;
    logic        pending_reg, pending_next;

    logic        is_write;
    logic        write_count;
    logic        loaded;
    logic [7:0]  tick_loaded;
    logic        gated;
    logic        inc;

    always_comb
    begin
        rsp.read_data = '0;
        if (req.func == FUNC_READ)
        begin
            unique case (req.reg_sel)
                SEL_DIV:   rsp.read_data = cycle_counter_reg[13:6];
                SEL_COUNT: rsp.read_data = tick_count_reg;
                SEL_MOD:   rsp.read_data = reload_value_reg;
                default:   rsp.read_data = {CTRL_READ_ONES, control_reg};
            endcase
        end
        rsp.timer_irq = pending_reg;
    end

    always_comb
    begin
        is_write    = (req.func == FUNC_WRITE);
        write_count = is_write && (req.reg_sel == SEL_COUNT);

        reload_value_next = (is_write && req.reg_sel == SEL_MOD) ? req.write_data
                                                                 : reload_value_reg;
        control_next      = (is_write && req.reg_sel == SEL_CTRL) ? req.write_data[2:0]
                                                                  : control_reg;

        loaded = pending_reg || write_count;
        if (write_count)
            tick_loaded = req.write_data;
        else if (pending_reg)
            tick_loaded = reload_value_next;
        else
            tick_loaded = tick_count_reg;

        cycle_counter_next = (is_write && req.reg_sel == SEL_DIV) ? 16'd0
                                                                  : cycle_counter_reg + 16'd1;

        gated           = rate_level(cycle_counter_next, control_next[1:0]) && control_next[2];
        inc             = prev_clk_reg && !gated && !loaded;
        tick_count_next = tick_loaded + {7'd0, inc};
        prev_clk_next   = gated;

        if (loaded)
        begin
            prev_top_next = 1'b0;
            pending_next  = 1'b0;
        end
        else
        begin
            prev_top_next = tick_count_next[7];
            pending_next  = prev_top_reg && !tick_count_next[7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_counter_reg <= '0;
            tick_count_reg    <= '0;
            reload_value_reg  <= '0;
            control_reg       <= '0;
            prev_clk_reg      <= 1'b0;
            prev_top_reg      <= 1'b0;
            pending_reg       <= 1'b0;
        end
        else if (step)
        begin
            cycle_counter_reg <= cycle_counter_next;
            tick_count_reg    <= tick_count_next;
            reload_value_reg  <= reload_value_next;
            control_reg       <= control_next;
            prev_clk_reg      <= prev_clk_next;
            prev_top_reg      <= prev_top_next;
            pending_reg       <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/divider_timer_with_reload.sv =====
// Divider and timer with overflow reload. Each req transaction is one machine cycle,
// optionally a register read or write (divider, counter, modulo, control); each
// produces exactly one rsp transaction carrying the read byte and the timer interrupt
// pulse. One transaction per clock is sustained: the timer state updates in the
// accepting cycle and the result sits in an output register, so req_ready is high
// whenever that register is empty or being drained in the same cycle.
`default_nettype none

module divider_timer_with_reload (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire dtr_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output dtr_pkg::rsp_t      rsp
);
    import dtr_pkg::*;

    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  core_rsp;
    logic  take;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign take      = req_valid && req_ready;

    dtr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (take),
        .req   (req),
        .rsp   (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (req_ready)
            rsp_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            rsp_reg <= core_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
